@@ rtl/wrcg_pkg.sv @@
// Shared constants and types for the Weil ranging code generator.
package wrcg_pkg;

  localparam int unsigned POS_W = 14;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned EXP_LEN = 7;

  localparam logic [POS_W-1:0] LEGENDRE_PRIME = 14'd10223;
  localparam logic [POS_W-1:0] CODE_LENGTH = 14'd10230;
  localparam logic [POS_W-1:0] LAST_CHIP = 14'd10229;
  localparam logic [POS_W-1:0] HALF_PRIME = 14'd5111;

  // Bit k holds chip k of the expansion pattern 0,1,1,0,1,0,0.
  localparam logic [EXP_LEN-1:0] EXP_PATTERN = 7'b0010110;

  localparam logic [POS_W-1:0] WEIL_RESET = 14'd5111;
  localparam logic [POS_W-1:0] START_RESET = 14'd411;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIL_INDEX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSERTION_INDEX = 1'd1;

  typedef enum logic [1:0] {
    BLD_CLEAR,
    BLD_MARK,
    BLD_DONE
  } build_state_t;

endpackage

@@ rtl/weil_ranging_code_generator.sv @@
// Weil ranging code generator: Legendre store build, chip pipeline and output register.
// Path: an accepted word passes through the stage 1, stage 2 and output registers.
// Throughput: one chip per cycle while out_ready holds; the two Legendre reads share one cycle on two read ports.
// Reset: synchronous, active low. After reset the store is cleared, then the 5111 quadratic
// residues are marked, and only then does in_ready rise. Configuration registers return
// to w = 5111 and p = 412.
module weil_ranging_code_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_chip,
  output logic [wrcg_pkg::POS_W-1:0]           out_chip_position,
  output logic                                 out_period_end,
  input  logic                                 cfg_wr_en,
  input  logic [wrcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wrcg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wrcg_pkg::*;

  // Configuration, kept in the form the datapath uses.
  logic [POS_W-1:0] wmod_r, wmod_nxt;
  logic [POS_W-1:0] start_r, start_nxt;

  // Build sequencer.
  build_state_t     bld_state_r, bld_state_nxt;
  logic [POS_W-1:0] bld_cnt_r, bld_cnt_nxt;
  logic [POS_W-1:0] sq_r, sq_nxt;
  logic [POS_W-1:0] odd_r, odd_nxt;
  logic             mem_we;
  logic [POS_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             built;

  logic             mem [LEGENDRE_PRIME];

  // Pipeline.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             en_s1, en_s2, en_out;
  logic             accept;

  logic             s1_v_r;
  logic [POS_W-1:0] s1_a_r, s1_pos_r;
  logic             s1_pat_r, s1_patbit_r, s1_end_r;

  logic             s2_v_r;
  logic             rd_a_r, rd_b_r;
  logic [POS_W-1:0] s2_pos_r;
  logic             s2_pat_r, s2_patbit_r, s2_end_r;

  logic             out_v_r;
  logic             out_chip_r;
  logic [POS_W-1:0] out_pos_r;
  logic             out_end_r;

  // Stage 0 signals.
  logic [POS_W-1:0] cur_pos;
  logic [POS_W:0]   diff;
  logic [POS_W-1:0] t_idx;
  logic [POS_W-1:0] a_idx;
  logic             pat_sel;
  logic             pat_bit;

  // Stage 1 signals.
  logic [POS_W:0]   b_sum;
  logic [POS_W-1:0] b_idx;

  // ---------------- configuration ----------------
  always_comb begin
    wmod_nxt  = wmod_r;
    start_nxt = start_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WEIL_INDEX: begin
          wmod_nxt = (cfg_wdata >= LEGENDRE_PRIME) ? cfg_wdata - LEGENDRE_PRIME : cfg_wdata;
        end
        CFG_INSERTION_INDEX: begin
          // A zero insertion index behaves as one.
          start_nxt = (cfg_wdata == '0) ? '0 : cfg_wdata - 14'd1;
        end
        default: begin
          wmod_nxt  = wmod_r;
          start_nxt = start_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmod_r  <= WEIL_RESET;
      start_r <= START_RESET;
    end else begin
      wmod_r  <= wmod_nxt;
      start_r <= start_nxt;
    end
  end

  // ---------------- build sequencer ----------------
  always_comb begin
    bld_state_nxt = bld_state_r;
    case (bld_state_r)
      BLD_CLEAR: if (bld_cnt_r == LEGENDRE_PRIME - 14'd1) bld_state_nxt = BLD_MARK;
      BLD_MARK:  if (bld_cnt_r == HALF_PRIME) bld_state_nxt = BLD_DONE;
      BLD_DONE:  bld_state_nxt = BLD_DONE;
      default:   bld_state_nxt = BLD_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bld_cnt_r;
    mem_wdata = 1'b0;
    built     = 1'b0;
    case (bld_state_r)
      BLD_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = bld_cnt_r;
        mem_wdata = 1'b0;
      end
      BLD_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = sq_r;
        mem_wdata = 1'b1;
      end
      BLD_DONE: built = 1'b1;
      default: begin
        mem_we = 1'b0;
        built  = 1'b0;
      end
    endcase
  end

  // Squares come from (x+1)^2 = x^2 + (2x+1); only x up to (p-1)/2 is needed,
  // so one conditional subtract keeps the running square reduced.
  always_comb begin
    logic [POS_W:0] sq_sum;
    sq_sum      = {1'b0, sq_r} + {1'b0, odd_r};
    bld_cnt_nxt = bld_cnt_r;
    sq_nxt      = sq_r;
    odd_nxt     = odd_r;
    case (bld_state_r)
      BLD_CLEAR: begin
        if (bld_cnt_r == LEGENDRE_PRIME - 14'd1) begin
          bld_cnt_nxt = 14'd1;
          sq_nxt      = 14'd1;
          odd_nxt     = 14'd3;
        end else begin
          bld_cnt_nxt = bld_cnt_r + 14'd1;
        end
      end
      BLD_MARK: begin
        bld_cnt_nxt = bld_cnt_r + 14'd1;
        sq_nxt      = (sq_sum >= {1'b0, LEGENDRE_PRIME}) ?
                      POS_W'(sq_sum - {1'b0, LEGENDRE_PRIME}) : sq_sum[POS_W-1:0];
        odd_nxt     = odd_r + 14'd2;
      end
      default: begin
        bld_cnt_nxt = bld_cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_state_r <= BLD_CLEAR;
      bld_cnt_r   <= '0;
      sq_r        <= '0;
      odd_r       <= '0;
    end else begin
      bld_state_r <= bld_state_nxt;
      bld_cnt_r   <= bld_cnt_nxt;
      sq_r        <= sq_nxt;
      odd_r       <= odd_nxt;
    end
  end

  // ---------------- handshake ----------------
  // Each stage loads when it is empty or its contents move on.
  assign en_out   = !out_v_r || out_ready;
  assign en_s2    = !s2_v_r || en_out;
  assign en_s1    = !s1_v_r || en_s2;
  assign in_ready = built && en_s1;
  assign accept   = in_valid && in_ready;

  // ---------------- stage 0: position and code index ----------------
  always_comb begin
    cur_pos = in_restart ? '0 : pos_r;
    diff    = {1'b0, cur_pos} - {1'b0, start_r};
    pat_sel = 1'b0;
    pat_bit = 1'b0;
    if (cur_pos < start_r) begin
      t_idx = cur_pos;
    end else if (diff < (POS_W+1)'(EXP_LEN)) begin
      t_idx   = '0;
      pat_sel = 1'b1;
      pat_bit = EXP_PATTERN[diff[2:0]];
    end else begin
      t_idx = cur_pos - 14'(EXP_LEN);
    end
    a_idx   = (t_idx >= LEGENDRE_PRIME) ? t_idx - LEGENDRE_PRIME : t_idx;
    pos_nxt = (cur_pos == LAST_CHIP) ? '0 : cur_pos + 14'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) pos_r <= pos_nxt;
      if (en_s1) s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_a_r      <= a_idx;
      s1_pos_r    <= cur_pos;
      s1_pat_r    <= pat_sel;
      s1_patbit_r <= pat_bit;
      s1_end_r    <= (cur_pos == LAST_CHIP);
    end
  end

  // ---------------- stage 1: shifted index and store reads ----------------
  always_comb begin
    b_sum = {1'b0, s1_a_r} + {1'b0, wmod_r};
    b_idx = (b_sum >= {1'b0, LEGENDRE_PRIME}) ?
            POS_W'(b_sum - {1'b0, LEGENDRE_PRIME}) : b_sum[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      rd_a_r      <= mem[s1_a_r];
      rd_b_r      <= mem[b_idx];
      s2_pos_r    <= s1_pos_r;
      s2_pat_r    <= s1_pat_r;
      s2_patbit_r <= s1_patbit_r;
      s2_end_r    <= s1_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  // ---------------- stage 2: chip and output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_chip_r <= s2_pat_r ? s2_patbit_r : (rd_a_r ^ rd_b_r);
      out_pos_r  <= s2_pos_r;
      out_end_r  <= s2_end_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_chip          = out_chip_r;
  assign out_chip_position = out_pos_r;
  assign out_period_end    = out_end_r;

endmodule

@@ test/weil_ranging_code_generator_tb.sv @@
// Self-checking testbench for the Weil ranging code generator.
`timescale 1ns / 1ps

module weil_ranging_code_generator_tb;
  import wrcg_pkg::*;

  localparam int unsigned LEG_P = 10223;
  localparam int unsigned CODE_LEN = 10230;
  localparam int unsigned PAT_LEN = 7;
  // Bit k is chip k of the expansion pattern 0,1,1,0,1,0,0.
  localparam logic [PAT_LEN-1:0] EXPANSION = 7'b0010110;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    logic chip;
    logic [POS_W-1:0] pos;
    logic last;
  } chip_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_chip;
  logic [POS_W-1:0] out_chip_position;
  logic out_period_end;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WEIL_INDEX;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state.
  bit legendre_bits [0:LEG_P-1];
  int unsigned chip_count = 0;
  logic [CFG_DATA_W-1:0] weil_shift = WEIL_RESET;
  logic [CFG_DATA_W-1:0] insert_at = 14'd412;

  bit restart_queue[$];
  chip_word_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  weil_ranging_code_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_chip(out_chip),
    .out_chip_position(out_chip_position),
    .out_period_end(out_period_end),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit weil_bit(int unsigned t);
    int unsigned a;
    int unsigned b;
    a = t % LEG_P;
    b = (a + (int'(weil_shift) % LEG_P)) % LEG_P;
    return legendre_bits[a] ^ legendre_bits[b];
  endfunction

  function automatic bit ranging_chip(int unsigned n);
    int unsigned first;
    // An insertion index of zero behaves like one.
    first = (insert_at == 0) ? 0 : int'(insert_at) - 1;
    if (n < first) return weil_bit(n);
    if (n - first < PAT_LEN) return EXPANSION[n - first];
    return weil_bit(n - PAT_LEN);
  endfunction

  function automatic chip_word_t next_chip_word(bit restart);
    chip_word_t w;
    int unsigned pos;
    pos = restart ? 0 : chip_count;
    if (pos >= CODE_LEN) pos = 0;
    w.chip = ranging_chip(pos);
    w.pos = pos[POS_W-1:0];
    w.last = (pos == CODE_LEN - 1);
    chip_count = (pos + 1 >= CODE_LEN) ? 0 : pos + 1;
    return w;
  endfunction

  task automatic log_failure(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Input driver: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (restart_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_restart <= restart_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with a one-time long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    chip_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          log_failure($sformatf("unexpected word at position %0d", out_chip_position));
        end else begin
          want = expected_words.pop_front();
          if (out_chip !== want.chip)
            log_failure($sformatf("chip at position %0d: got %0b, expected %0b",
                                  want.pos, out_chip, want.chip));
          if (out_chip_position !== want.pos)
            log_failure($sformatf("chip_position: got %0d, expected %0d",
                                  out_chip_position, want.pos));
          if (out_period_end !== want.last)
            log_failure($sformatf("period_end at position %0d: got %0b, expected %0b",
                                  want.pos, out_period_end, want.last));
        end
      end
      if (in_valid && in_ready) expected_words.push_back(next_chip_word(in_restart));
    end
  end

  // The store build after reset runs with nothing moving, which the watchdog limit must allow for.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[weil_ranging_code_generator] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_config(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] p);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WEIL_INDEX;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_INSERTION_INDEX;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weil_shift = w;
    insert_at = p;
    @(negedge clk);
  endtask

  task automatic queue_random(int unsigned count, int unsigned restart_pct);
    repeat (count) restart_queue.push_back($urandom_range(99) < restart_pct);
  endtask

  task automatic drain();
    @(negedge clk);
    while (restart_queue.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    for (int unsigned x = 1; x < LEG_P; x++) legendre_bits[(x * x) % LEG_P] = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    // Reset values of both registers, plain steps and restarts.
    tx_idle_pct = 36;
    rx_idle_pct = 78;
    repeat (PAT_LEN) restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    restart_queue.push_back(1'b1);
    repeat (5) restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    repeat (6) restart_queue.push_back(1'b0);
    drain();

    set_config(14'd1, 14'd1);
    queue_random(80, 4);
    drain();
    set_config(14'd10222, 14'd10223);
    queue_random(80, 4);
    drain();

    tx_idle_pct = 78;
    rx_idle_pct = 36;
    // A zero shift gives an all-zero Weil code; a zero insertion index acts as one.
    set_config(14'd0, 14'd0);
    queue_random(80, 4);
    drain();
    set_config(14'h3FFF, 14'h3FFF);
    queue_random(80, 4);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(14'($urandom_range(16383)), 14'($urandom_range(1, 40)));
    queue_random(110, 3);
    hold_armed = 1'b1;
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[weil_ranging_code_generator] OK");
    end else begin
      $display("[weil_ranging_code_generator] ERROR");
    end
    $finish;
  end

endmodule
